// ----- src/bsp2_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp2_pkg
// Shared constants and stage payload types for the binary32 scale unit.
// ----------------------------------------------------------------------------
package bsp2_pkg;

  localparam logic [31:0] SignMask  = 32'h8000_0000;
  localparam logic [31:0] ExpMask   = 32'h7F80_0000;
  localparam logic [31:0] FracMask  = 32'h007F_FFFF;
  localparam logic [23:0] HiddenBit = 24'h80_0000;
  localparam int          ExpBias   = 127;
  localparam int          FracBits  = 23;
  localparam int          NonFrac   = 9;

  // Signed exponent width: scale (32b) plus unpacked exponent never wraps
  localparam int          EW        = 34;

  // Stage 1 -> 2: decoded operand
  typedef struct packed {
    logic              sign;
    logic              pass;
    logic [31:0]       raw;
    logic [23:0]       sig;
    logic signed [EW-1:0] e;
  } dec_t;

  // Stage 2 -> 3: classified result before rounding
  typedef struct packed {
    logic              sign;
    logic              pass;
    logic              ovf;
    logic              norm;
    logic              zero;
    logic [31:0]       raw;
    logic [23:0]       sig;
    logic [7:0]        bexp;
    logic [4:0]        sh;
  } cls_t;

endpackage

// ----- src/bsp2_decode.sv -----
// ----------------------------------------------------------------------------
// bsp2_decode
// Unpacks the operand, normalizes subnormals and forms the scaled exponent.
// ----------------------------------------------------------------------------
module bsp2_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [31:0]        value_bits_i,
  input  logic signed [31:0] scale_i,
  output logic               valid_o,
  output bsp2_pkg::dec_t     dec_o
);

  logic [7:0]  expf;
  logic [22:0] frac;
  logic [4:0]  lz;
  logic [4:0]  s;
  bsp2_pkg::dec_t dec_d, dec_q;
  logic valid_q;

  assign expf = value_bits_i[30:23];
  assign frac = value_bits_i[22:0];

  // Count leading zeros of the fraction (priority search)
  always_comb begin
    lz = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (frac[i]) lz = 5'(22 - i);
    end
  end

  // Normalizing shift brings the top set bit to bit 23
  assign s = lz + 5'd1;

  always_comb begin
    dec_d.sign = value_bits_i[31];
    dec_d.raw  = value_bits_i;
    dec_d.pass = (expf == 8'hFF) || (value_bits_i[30:0] == 31'd0);
    if (expf != 8'd0) begin
      dec_d.sig = {1'b1, frac};
      dec_d.e   = bsp2_pkg::EW'($signed({1'b0, expf})) - bsp2_pkg::EW'(bsp2_pkg::ExpBias)
                  + bsp2_pkg::EW'(scale_i);
    end else begin
      dec_d.sig = 24'({1'b0, frac} << s);
      dec_d.e   = bsp2_pkg::EW'(1 - bsp2_pkg::ExpBias)
                  - bsp2_pkg::EW'($signed({1'b0, s})) + bsp2_pkg::EW'(scale_i);
    end
  end

  // Advance the stage when downstream moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// ----- src/bsp2_classify.sv -----
// ----------------------------------------------------------------------------
// bsp2_classify
// Compares the scaled exponent against the normal range, picks the shift.
// ----------------------------------------------------------------------------
module bsp2_classify (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  bsp2_pkg::dec_t dec_i,
  output logic           valid_o,
  output bsp2_pkg::cls_t cls_o
);

  localparam int EW = bsp2_pkg::EW;

  logic signed [EW-1:0] r;
  bsp2_pkg::cls_t cls_d, cls_q;
  logic valid_q;

  // Right shift distance below the normal range
  assign r = EW'(1 - bsp2_pkg::ExpBias) - dec_i.e;

  always_comb begin
    cls_d.sign = dec_i.sign;
    cls_d.pass = dec_i.pass;
    cls_d.raw  = dec_i.raw;
    cls_d.sig  = dec_i.sig;
    cls_d.ovf  = dec_i.e > EW'(bsp2_pkg::ExpBias);
    cls_d.norm = dec_i.e >= EW'(1 - bsp2_pkg::ExpBias);
    cls_d.zero = r >= EW'(25);
    cls_d.bexp = 8'(dec_i.e + EW'(bsp2_pkg::ExpBias));
    cls_d.sh   = r[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;

endmodule

// ----- src/bsp2_round.sv -----
// ----------------------------------------------------------------------------
// bsp2_round
// Denormalizes with round-half-to-even and assembles the result word.
// ----------------------------------------------------------------------------
module bsp2_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  bsp2_pkg::cls_t cls_i,
  output logic           valid_o,
  output logic [31:0]    result_o
);

  logic [23:0] q;
  logic [23:0] msk;
  logic [23:0] rem;
  logic [23:0] half;
  logic [23:0] qr;
  logic [31:0] res_d, res_q;
  logic valid_q;

  // Shift is 1..24 on this path
  assign q    = cls_i.sig >> cls_i.sh;
  assign msk  = (24'd1 << cls_i.sh) - 24'd1;
  assign rem  = cls_i.sig & msk;
  assign half = 24'd1 << (cls_i.sh - 5'd1);
  assign qr   = ((rem > half) || ((rem == half) && q[0])) ? q + 24'd1 : q;

  always_comb begin
    if (cls_i.pass) begin
      res_d = cls_i.raw;
    end else if (cls_i.ovf) begin
      res_d = {cls_i.sign, 31'd0} | bsp2_pkg::ExpMask;
    end else if (cls_i.norm) begin
      res_d = {cls_i.sign, cls_i.bexp, cls_i.sig[22:0]};
    end else if (cls_i.zero) begin
      res_d = {cls_i.sign, 31'd0};
    end else begin
      res_d = {cls_i.sign, 7'd0, qr};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ----- src/binary32_scale_by_power_of_two.sv -----
// ----------------------------------------------------------------------------
// binary32_scale_by_power_of_two
// Multiplies a binary32 value by two to a signed integer power.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  request  | in_valid_i, in_stall_o, fields   | in
//  result   | out_valid_o, out_stall_i, field  | out
//
// Three register stages (decode, classify, round).
// One request enters per cycle while the output is not stalled.
// A stall freezes each full stage with no empty stage ahead of it; nothing is lost or repeated.
// A bubble in the pipe is filled even while the output is stalled.
// Reset clears the valid bits only.
module binary32_scale_by_power_of_two (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        value_bits_i,
  input  logic signed [31:0] scale_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        result_bits_o
);

  logic v1, v2, v3;
  logic a1, a2, a3;
  bsp2_pkg::dec_t dec;
  bsp2_pkg::cls_t cls;

  // Advance a stage when its slot is empty or the next one moves
  assign a3 = !v3 || !out_stall_i;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign in_stall_o = !a1;

  bsp2_decode u_dec (
    .clk_i, .rst_ni, .adv_i(a1), .valid_i(in_valid_i),
    .value_bits_i, .scale_i, .valid_o(v1), .dec_o(dec)
  );

  bsp2_classify u_cls (
    .clk_i, .rst_ni, .adv_i(a2), .valid_i(v1), .dec_i(dec),
    .valid_o(v2), .cls_o(cls)
  );

  bsp2_round u_rnd (
    .clk_i, .rst_ni, .adv_i(a3), .valid_i(v2), .cls_i(cls),
    .valid_o(v3), .result_o(result_bits_o)
  );

  assign out_valid_o = v3;

  // Hold the output while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_bits_o))
    else $error("result changed under stall");

  // Accept only when the first stage can advance
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1)
    else $error("accepted request lost");

  // Free output means no input stall
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("stall without backpressure");

endmodule

// ----- test/binary32_scale_by_power_of_two_tb.sv -----
// ----------------------------------------------------------------------------
// binary32_scale_by_power_of_two_tb
// Drives binary32 operands and scales through the request channel with random
// idle bursts and result stalls, and compares every result against a local
// scalb predictor.
// ----------------------------------------------------------------------------
module binary32_scale_by_power_of_two_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int TailCycles    = 10;

  typedef struct packed {
    logic [31:0]        value_bits;
    logic signed [31:0] scale;
  } request_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        value_bits_i;
  logic signed [31:0] scale_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [31:0]        result_bits_o;

  request_t    pending_q[$];
  logic [31:0] scaled_q[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          quiet_phase;
  bit          stim_done;

  binary32_scale_by_power_of_two u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_bits_i (value_bits_i),
    .scale_i      (scale_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_bits_o(result_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Predict value * 2**scale with a wide exponent so the sum never wraps
  function automatic logic [31:0] scalb_predict(logic [31:0] x, logic signed [31:0] k);
    logic        sgn;
    logic [7:0]  ef;
    logic [22:0] fr;
    logic [23:0] sig;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    longint      e;
    longint      r;
    int          lz;
    sgn = x[31];
    ef  = x[30:23];
    fr  = x[22:0];
    if (ef == 8'hFF || x[30:0] == 31'd0) return x;
    if (ef != 8'd0) begin
      sig = {1'b1, fr};
      e   = longint'(ef) - bsp2_pkg::ExpBias;
    end else begin
      lz = 0;
      while (fr[22 - lz] == 1'b0) lz++;
      sig = {1'b0, fr} << (lz + 1);
      e   = 1 - bsp2_pkg::ExpBias - (lz + 1);
    end
    e = e + longint'(k);
    if (e > bsp2_pkg::ExpBias) return {sgn, 31'h7F80_0000};
    if (e >= 1 - bsp2_pkg::ExpBias) return {sgn, 8'(e + bsp2_pkg::ExpBias), sig[22:0]};
    r = (1 - bsp2_pkg::ExpBias) - e;
    if (r >= 25) return {sgn, 31'd0};
    q    = sig >> r;
    rem  = sig & ((24'd1 << r) - 24'd1);
    half = 24'd1 << (r - 1);
    if (rem > half || (rem == half && q[0])) q = q + 24'd1;
    return {sgn, 7'd0, q};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'hFF;
      2: v[30:0]  = 31'd0;
      3: v[30:0]  = 31'd1 << $urandom_range(0, 22);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] random_scale();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return -$signed(32'($urandom_range(120, 180)));
      3: return $signed(32'($urandom_range(100, 300)));
      default: return $signed(32'($urandom_range(0, 80))) - 40;
    endcase
  endfunction

  // Fill the request queue: directed corners first, then random
  initial begin
    logic [31:0]        corner_v[14];
    logic signed [31:0] corner_s[14];
    corner_v = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF, 32'h0080_0000,
                 32'h3FC0_0000, 32'h3F80_0001};
    corner_s = '{32'sd5, -32'sd5, 32'sd3, -32'sd3, 32'sd1, 32'sh8000_0000,
                 32'sd0, 32'sd1, 32'sd128, -32'sd127, 32'sh7FFF_FFFF, -32'sd1,
                 -32'sd149, -32'sd126};
    for (int i = 0; i < 14; i++) pending_q.push_back('{corner_v[i], corner_s[i]});
    // rounding ties and carry into the smallest normal
    pending_q.push_back('{32'h3F80_0000, -32'sd150});
    pending_q.push_back('{32'h3FC0_0000, -32'sd150});
    pending_q.push_back('{32'h3FC0_0000, -32'sd149});
    pending_q.push_back('{32'h3F7F_FFFF, -32'sd126});
    pending_q.push_back('{32'h0000_0001, 32'sd276});
    pending_q.push_back('{32'h0000_0001, -32'sd1});
    pending_q.push_back('{32'h7F7F_FFFF, 32'sh8000_0000});
    for (int i = 0; i < 950; i++) pending_q.push_back('{random_value(), random_scale()});
  end

  // Reset, then wait for drain and settle
  initial begin
    rst_ni = 1'b0;
    mismatch_count = 0;
    stim_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && scaled_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (scaled_q.size() != 0) report_mismatch("leftover", 32'd0, scaled_q[0]);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Drive requests, inserting random idle bursts
  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      value_bits_i <= '0;
      scale_i      <= '0;
      in_gap       = 0;
    end else begin
      quiet_phase = pending_q.size() < 150;
      if (in_valid_i && !in_stall_o) begin
        scaled_q.push_back(scalb_predict(value_bits_i, scale_i));
        void'(pending_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap == 0 && !quiet_phase && $urandom_range(0, 15) == 0)
          in_gap = $urandom_range(1, 12);
        if (in_gap > 0 || pending_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i   <= 1'b1;
          value_bits_i <= pending_q[0].value_bits;
          scale_i      <= pending_q[0].scale;
        end
      end
    end
  end

  // Check results and hold random stall bursts
  int out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap     = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (scaled_q.size() == 0) begin
          report_mismatch("unexpected", result_bits_o, 32'd0);
        end else begin
          logic [31:0] want;
          want = scaled_q.pop_front();
          if (result_bits_o !== want) report_mismatch("result_bits", result_bits_o, want);
        end
      end
      if (out_gap == 0 && !quiet_phase && $urandom_range(0, 15) == 0)
        out_gap = $urandom_range(1, 12);
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run after too long with no request accepted and no result taken
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
